// ----- hw/rtl/bfe_pkg.sv -----
// ============================================================================
// bfe_pkg: shared types and constants of the Bloom filter engine
// Item and result records, register indexes, and the hash round constants.
// ============================================================================
package bfe_pkg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_TEST   = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] key;
    } item_t;

    typedef struct packed {
        logic        found;
        logic        cleared;
        logic [31:0] remaining;
    } result_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd2;

    localparam int PROBE_W = 6;
    localparam int WCOUNT_W = 11;
    localparam int CFG_DATA_W = 32;
    localparam logic [PROBE_W-1:0]  PROBE_RESET = 6'd7;
    localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 11'd1024;

    // Remainder unit: the 58-bit word position, padded to 60 bits, 4 bits a cycle.
    localparam int DIV_BITS  = 60;
    localparam int DIV_STEP  = 4;
    localparam int DIV_ITERS = DIV_BITS / DIV_STEP;

    // Hash round constants.
    localparam logic [63:0] PR1 = 64'd11400714785074694791;
    localparam logic [63:0] PR2 = 64'd14029467366897019727;
    localparam logic [63:0] PR3 = 64'd1609587929392839161;
    localparam logic [63:0] PR4 = 64'd9650029242287828579;
    localparam logic [63:0] MIX_SEED = 64'd2870177450012600269;  // PR5 + 8

    // Hash steps; each is one 64-bit multiply with some mixing around it.
    localparam logic [2:0] HS_KEY   = 3'd0;
    localparam logic [2:0] HS_ROUND = 3'd1;
    localparam logic [2:0] HS_AVAL  = 3'd2;
    localparam logic [2:0] HS_FIN1  = 3'd3;
    localparam logic [2:0] HS_FIN2  = 3'd4;

    function automatic logic [63:0] hash_const(input logic [2:0] step);
        logic [63:0] k;
        unique case (step)
            HS_KEY:   k = PR2;
            HS_ROUND: k = PR1;
            HS_AVAL:  k = PR1;
            HS_FIN1:  k = PR2;
            HS_FIN2:  k = PR3;
            default:  k = PR3;
        endcase
        return k;
    endfunction

    // Operand preparation before the multiply of a step.
    function automatic logic [63:0] hash_pre(input logic [2:0] step, input logic [63:0] v);
        logic [63:0] x;
        unique case (step)
            HS_ROUND: x = {v[32:0], v[63:33]};   // rotate left 31
            HS_AVAL:  x = {v[36:0], v[63:37]};   // rotate left 27
            default:  x = v;
        endcase
        return x;
    endfunction

    // Mixing after the multiply of a step.
    function automatic logic [63:0] hash_post(input logic [2:0] step, input logic [63:0] p);
        logic [63:0] t;
        logic [63:0] y;
        t = p + PR4;
        unique case (step)
            HS_ROUND: y = MIX_SEED ^ p;
            HS_AVAL:  y = t ^ (t >> 33);
            HS_FIN1:  y = p ^ (p >> 29);
            HS_FIN2:  y = p ^ (p >> 32);
            default:  y = p;
        endcase
        return y;
    endfunction

endpackage

// ----- hw/rtl/bloom_filter_engine.sv -----
// ============================================================================
// bloom_filter_engine: Bloom filter over a store of 64-bit words
// Inserts and tests 64-bit key hashes with a configurable number of probes.
// ============================================================================
// Usage. Items enter through a queue-like port: an item transfers when push is
// high and full is low; opcode 0 inserts key_hash, opcode 1 tests it. Up to two
// items wait in the input queue while the execution side works.
// Results leave through a second queue-like port: while empty is low the oldest
// result (found, cleared, remaining) is shown, and it transfers when pop is high.
// One result register holds a finished result, so a stalled receiver only holds
// up the block once the next item is also done; nothing is dropped.
// Configuration writes transfer on cfg_valid and cfg_ready (always high); index
// 0 is probe_count, 1 word_count, 2 capacity (also reloads the counter).
// Probes. Each probe is paced by the hash unit (five 64-bit multiplies, each
// built from three partial products) with the remainder unit in parallel,
// plus one store read and, for an insert, one store write. A test stops at
// its first clear bit. An insert that clears first sweeps word_count words
// (held to 1..WORDS) at one word a cycle.
// Reset. After reset all WORDS words of the store are swept to zero, during which
// no item is taken; configuration writes are accepted at any time.
module bloom_filter_engine
#(
    parameter int WORDS      = 1024,
    parameter int MAX_PROBES = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            opcode,
    input  logic [63:0]                     key_hash,
    output logic                            empty,
    input  logic                            pop,
    output logic                            found,
    output logic                            cleared,
    output logic [31:0]                     remaining,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Link between the input queue and the execution side.
    logic             item_valid;
    bfe_pkg::item_t   item;
    logic             item_take;
    logic             res_valid;
    bfe_pkg::result_t res;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    bfe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .key_hash   (key_hash),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    bfe_back #(.WORDS(WORDS), .MAX_PROBES(MAX_PROBES)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (pop)
    );

    // The result port shows the result register directly.
    assign empty     = !res_valid;
    assign found     = res.found;
    assign cleared   = res.cleared;
    assign remaining = res.remaining;

endmodule

// ----- hw/rtl/bfe_front.sv -----
// ============================================================================
// bfe_front: input queue of the Bloom filter engine
// Takes items from the push side, classifies the opcode and holds up to two.
// ============================================================================
module bfe_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              opcode,
    input  logic [63:0]       key_hash,
    output logic              item_valid,
    output bfe_pkg::item_t    item,
    input  logic              item_take
);

    bfe_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_take;
    bfe_pkg::item_t incoming;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_take    = item_take && item_valid;

    always_comb
    begin
        incoming.op  = opcode ? bfe_pkg::OP_TEST : bfe_pkg::OP_INSERT;
        incoming.key = key_hash;
        wr_ptr_next  = wr_ptr_reg ^ do_push;
        rd_ptr_next  = rd_ptr_reg ^ do_take;
        count_next   = count_reg + {1'b0, do_push} - {1'b0, do_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ----- hw/rtl/bfe_hash.sv -----
// ============================================================================
// bfe_hash: multi-cycle probe hash unit
// Five 64-bit multiplies, each built from three 32x32 partial products.
// ============================================================================
module bfe_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] din,
    output logic        done,
    output logic [63:0] dout
);

    logic [2:0]  step_reg;
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] dout_reg;
    logic [63:0] k;
    logic [31:0] a32;
    logic [31:0] b32;
    logic [63:0] prod;
    logic [63:0] addend;
    logic [63:0] mixed;

    assign done = done_reg;
    assign dout = dout_reg;

    always_comb
    begin
        k      = bfe_pkg::hash_const(step_reg);
        a32    = (phase_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
        b32    = (phase_reg == 2'd1) ? k[63:32] : k[31:0];
        prod   = {32'd0, a32} * {32'd0, b32};
        addend = (phase_reg == 2'd0) ? prod : {prod[31:0], 32'd0};
        mixed  = bfe_pkg::hash_post(step_reg, acc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= bfe_pkg::HS_KEY;
            phase_reg <= 2'd0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            step_reg  <= bfe_pkg::HS_KEY;
            phase_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            phase_reg <= phase_reg + 2'd1;
            if (phase_reg == 2'd3)
            begin
                if (step_reg == bfe_pkg::HS_FIN2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= din;
            acc_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            if (phase_reg == 2'd3)
            begin
                x_reg    <= bfe_pkg::hash_pre(step_reg + 3'd1, mixed);
                acc_reg  <= 64'd0;
                dout_reg <= mixed;
            end
            else
            begin
                acc_reg <= acc_reg + addend;
            end
        end
    end

endmodule

// ----- hw/rtl/bfe_mod.sv -----
// ============================================================================
// bfe_mod: iterative remainder unit
// Reduces the word position modulo the word count, four bits per cycle.
// ============================================================================
module bfe_mod
#(
    parameter int DW = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [57:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] rem
);

    localparam int CNT_W = $clog2(bfe_pkg::DIV_ITERS);

    logic [bfe_pkg::DIV_BITS-1:0] q_reg;
    logic [DW-1:0]  r_reg;
    logic [DW-1:0]  r_next;
    logic [CNT_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    assign done = done_reg;
    assign rem  = r_reg;

    always_comb
    begin
        logic [DW:0] t;
        r_next = r_reg;
        for (int j = 0; j < bfe_pkg::DIV_STEP; j++)
        begin
            t = {r_next, q_reg[bfe_pkg::DIV_BITS-1-j]};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r_next = t[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(bfe_pkg::DIV_ITERS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= {2'b00, dividend};
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= q_reg << bfe_pkg::DIV_STEP;
            r_reg <= r_next;
        end
    end

endmodule

// ----- hw/rtl/bfe_back.sv -----
// ============================================================================
// bfe_back: execution side of the Bloom filter engine
// Holds the bit store and registers, runs probes and clears, keeps the result.
// ============================================================================
module bfe_back
#(
    parameter int WORDS      = 1024,
    parameter int MAX_PROBES = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  bfe_pkg::item_t                    item,
    output logic                              item_take,
    input  logic                              cfg_we,
    input  logic [bfe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfe_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              res_valid,
    output bfe_pkg::result_t                  res,
    input  logic                              res_take
);

    localparam int AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NW_W = $clog2(WORDS + 1);
    localparam int PC_W = $clog2(MAX_PROBES + 1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CLEAR = 7'b0000100,
        S_START = 7'b0001000,
        S_CALC  = 7'b0010000,
        S_MEM   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [bfe_pkg::PROBE_W-1:0]  probe_reg;
    logic [bfe_pkg::WCOUNT_W-1:0] wcount_reg;
    logic [31:0] cap_reg;
    logic [31:0] rem_reg;

    logic [63:0] mem [WORDS];
    logic [63:0] rdata_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0] mem_wdata;
    logic        mem_re;

    bfe_pkg::op_t op_reg;
    logic [63:0]  h_reg;
    logic [PC_W-1:0] left_reg;
    logic [AW-1:0] addr_reg;
    logic [5:0]   bit_reg;
    logic [AW-1:0] clr_idx_reg;
    logic         found_reg;
    logic         cleared_reg;
    logic         res_valid_reg;
    bfe_pkg::result_t res_reg;

    logic [NW_W-1:0] nw_eff;
    logic [PC_W-1:0] np_eff;
    logic [NW_W-1:0] clr_limit;
    logic            clr_last;
    logic            calc_done;
    logic            need_clear;
    logic            res_load;

    logic        hash_start;
    logic        hash_done;
    logic [63:0] hash_out;
    logic        mod_done;
    logic [NW_W-1:0] mod_rem;

    bfe_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .din   (h_reg),
        .done  (hash_done),
        .dout  (hash_out)
    );

    bfe_mod #(.DW(NW_W)) u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (hash_start),
        .dividend (h_reg[63:6]),
        .divisor  (nw_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign item_take = (state_reg == S_IDLE);

    always_comb
    begin
        if (wcount_reg == '0)
        begin
            nw_eff = NW_W'(1);
        end
        else if (32'(wcount_reg) > 32'(WORDS))
        begin
            nw_eff = NW_W'(WORDS);
        end
        else
        begin
            nw_eff = NW_W'(wcount_reg);
        end

        if (32'(probe_reg) > 32'(MAX_PROBES))
        begin
            np_eff = PC_W'(MAX_PROBES);
        end
        else
        begin
            np_eff = PC_W'(probe_reg);
        end

        clr_limit  = (state_reg == S_INIT) ? NW_W'(WORDS) : nw_eff;
        clr_last   = (NW_W'(clr_idx_reg) == clr_limit - NW_W'(1));
        calc_done  = hash_done && mod_done;
        need_clear = (rem_reg == 32'd0) || (rem_reg > cap_reg);
        res_load   = (state_reg == S_DONE) && (!res_valid_reg || res_take);
        hash_start = (state_reg == S_START) && (left_reg != '0);

        mem_we    = 1'b0;
        mem_waddr = clr_idx_reg;
        mem_wdata = 64'd0;
        if ((state_reg == S_INIT) || (state_reg == S_CLEAR))
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == S_MEM) && (op_reg == bfe_pkg::OP_INSERT))
        begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg;
            mem_wdata = rdata_reg | (64'd1 << bit_reg);
        end
        mem_re = (state_reg == S_CALC) && calc_done;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if ((item.op == bfe_pkg::OP_INSERT) && need_clear)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = (left_reg == '0) ? S_DONE : S_CALC;
            end
            S_CALC:
            begin
                if (calc_done)
                begin
                    state_next = S_MEM;
                end
            end
            S_MEM:
            begin
                if ((op_reg == bfe_pkg::OP_TEST) && !rdata_reg[bit_reg])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_START;
                end
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            probe_reg     <= bfe_pkg::PROBE_RESET;
            wcount_reg    <= bfe_pkg::WCOUNT_RESET;
            cap_reg       <= 32'd0;
            rem_reg       <= 32'd0;
            res_valid_reg <= 1'b0;
            clr_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= (res_valid_reg && !res_take) || res_load;

            if ((state_reg == S_INIT) || (state_reg == S_CLEAR))
            begin
                clr_idx_reg <= clr_last ? '0 : clr_idx_reg + 1'b1;
            end

            if ((state_reg == S_IDLE) && item_valid && (item.op == bfe_pkg::OP_INSERT))
            begin
                rem_reg <= need_clear ? cap_reg : rem_reg - 32'd1;
            end

            if (cfg_we)
            begin
                priority case (cfg_index)
                    bfe_pkg::CFG_PROBE_COUNT:
                        probe_reg <= cfg_data[bfe_pkg::PROBE_W-1:0];
                    bfe_pkg::CFG_WORD_COUNT:
                        wcount_reg <= cfg_data[bfe_pkg::WCOUNT_W-1:0];
                    bfe_pkg::CFG_CAPACITY:
                    begin
                        cap_reg <= cfg_data;
                        rem_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Item context, probe bookkeeping and result payload.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg      <= item.op;
                h_reg       <= item.key;
                left_reg    <= np_eff;
                found_reg   <= (item.op == bfe_pkg::OP_TEST);
                cleared_reg <= (item.op == bfe_pkg::OP_INSERT) && need_clear;
            end
            S_CALC:
            begin
                if (calc_done)
                begin
                    addr_reg <= mod_rem[AW-1:0];
                    bit_reg  <= h_reg[5:0];
                    h_reg    <= hash_out;
                    left_reg <= left_reg - 1'b1;
                end
            end
            S_MEM:
            begin
                if ((op_reg == bfe_pkg::OP_TEST) && !rdata_reg[bit_reg])
                begin
                    found_reg <= 1'b0;
                end
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    res_reg.found     <= found_reg;
                    res_reg.cleared   <= cleared_reg;
                    res_reg.remaining <= rem_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mod_rem[AW-1:0]];
        end
    end

endmodule

// ----- hw/rtl/bfe_checker.sv -----
// ============================================================================
// bfe_checker: port-level checks of the Bloom filter engine
// Watches the result port over time; bound to the top level.
// ============================================================================
module bfe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        found,
    input logic        cleared,
    input logic [31:0] remaining
);

    // A waiting result stays until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
    else $error("result withdrawn before transfer");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(found) && $stable(cleared) && $stable(remaining)))
    else $error("stalled result changed");

    // Only tests report found and only inserts report cleared, so no result shows both.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(found && cleared))
    else $error("result reports both found and cleared");

    // No result is shown right after reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
    else $error("result present after reset");

endmodule

bind bloom_filter_engine bfe_checker u_bfe_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .found     (found),
    .cleared   (cleared),
    .remaining (remaining)
);
